FILE: rtl/lwm2m_tlv_stream_parser_macros.svh
// Assertion macros shared by the TLV stream parser modules.
`ifndef LWM2M_TLV_STREAM_PARSER_MACROS_SVH
`define LWM2M_TLV_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LTSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LTSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ltsp_pkg.sv
// Types and constants of the LwM2M TLV stream parser.
package ltsp_pkg;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_ID,
    PH_LEN,
    PH_VALUE
  } phase_t;

  localparam logic [1:0] KIND_OBJ_INST  = 2'd0;
  localparam logic [1:0] KIND_RES_INST  = 2'd1;
  localparam logic [1:0] KIND_MULTI_RES = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  localparam int LEN_W = 24;
  localparam int ID_W  = 16;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_end;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  object_instance_id;
    logic [ID_W-1:0]  resource_id;
    logic [ID_W-1:0]  resource_instance_id;
    logic             is_instance_value;
    logic [7:0]       value_byte;
    logic             value_present;
    logic             value_last;
    logic [LEN_W-1:0] value_length;
    logic             status;
  } out_item_t;

  typedef struct packed {
    logic      have;
    out_item_t data;
  } step_res_t;

endpackage

FILE: rtl/ltsp_if.sv
// Valid/ready channel interfaces for payload bytes and parsed value results.
interface ltsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_end;

  modport source (output valid, output payload_byte, output payload_end, input ready);
  modport sink (input valid, input payload_byte, input payload_end, output ready);
endinterface

interface ltsp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] object_instance_id;
  logic [15:0] resource_id;
  logic [15:0] resource_instance_id;
  logic        is_instance_value;
  logic [7:0]  value_byte;
  logic        value_present;
  logic        value_last;
  logic [23:0] value_length;
  logic        status;

  modport source (
    output valid, output object_instance_id, output resource_id,
    output resource_instance_id, output is_instance_value, output value_byte,
    output value_present, output value_last, output value_length, output status,
    input ready
  );
  modport sink (
    input valid, input object_instance_id, input resource_id,
    input resource_instance_id, input is_instance_value, input value_byte,
    input value_present, input value_last, input value_length, input status,
    output ready
  );
endinterface

FILE: rtl/ltsp_in_stage.sv
// Input register that captures one payload byte per transaction.
module ltsp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  ltsp_in_if.sink           in_ch,
  input  logic              take,
  output ltsp_pkg::in_item_t item,
  output logic              item_vld
);

  ltsp_pkg::in_item_t item_r;
  logic               vld_r;
  logic               vld_nxt;
  logic               accept;

  assign in_ch.ready = !vld_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.payload_byte <= in_ch.payload_byte;
      item_r.payload_end  <= in_ch.payload_end;
    end
  end

  assign item     = item_r;
  assign item_vld = vld_r;

endmodule

FILE: rtl/ltsp_step.sv
// Parser state and the per-byte TLV decode step with container tracking.
`include "lwm2m_tlv_stream_parser_macros.svh"

module ltsp_step #(
  parameter int NEST_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  ltsp_pkg::in_item_t  item,
  output ltsp_pkg::step_res_t res
);

  localparam int LVL_W = $clog2(NEST_DEPTH + 1);
  localparam int LEN_W = ltsp_pkg::LEN_W;
  localparam int ID_W  = ltsp_pkg::ID_W;

  ltsp_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [1:0]       id_left_r, id_left_nxt;
  logic [1:0]       len_left_r, len_left_nxt;
  logic [ID_W-1:0]  id_acc_r, id_acc_nxt;
  logic [LEN_W-1:0] len_acc_r, len_acc_nxt;
  logic [LEN_W-1:0] vleft_r, vleft_nxt;
  logic [LEN_W-1:0] rem_r [NEST_DEPTH];
  logic [LEN_W-1:0] rem_nxt [NEST_DEPTH];
  logic [LVL_W-1:0] lvl_r, lvl_push, lvl_nxt;
  logic [ID_W-1:0]  inst_r, inst_nxt;
  logic [ID_W-1:0]  resid_r, resid_nxt;
  logic [ID_W-1:0]  rinst_r, rinst_nxt;
  logic             hdr_done;
  logic             have;
  logic             present;
  logic             last;
  logic             is_rinst;
  logic             trunc;
  logic [7:0]       b;

  assign b = item.payload_byte;

  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    id_left_nxt  = id_left_r;
    len_left_nxt = len_left_r;
    id_acc_nxt   = id_acc_r;
    len_acc_nxt  = len_acc_r;
    vleft_nxt    = vleft_r;
    inst_nxt     = inst_r;
    resid_nxt    = resid_r;
    rinst_nxt    = rinst_r;
    lvl_push     = lvl_r;
    hdr_done     = 1'b0;
    have         = 1'b0;
    present      = 1'b0;
    last         = 1'b0;

    // Every byte counts against each open container, saturating at zero.
    for (int i = 0; i < NEST_DEPTH; i++) begin
      if (LVL_W'(i) < lvl_r && rem_r[i] != '0) begin
        rem_nxt[i] = rem_r[i] - LEN_W'(1);
      end else begin
        rem_nxt[i] = rem_r[i];
      end
    end

    case (phase_r)
      ltsp_pkg::PH_TYPE: begin
        kind_nxt     = b[7:6];
        id_left_nxt  = b[5] ? 2'd2 : 2'd1;
        len_left_nxt = b[4:3];
        len_acc_nxt  = (b[4:3] != 2'd0) ? '0 : LEN_W'(b[2:0]);
        id_acc_nxt   = '0;
        phase_nxt    = ltsp_pkg::PH_ID;
      end
      ltsp_pkg::PH_ID: begin
        id_acc_nxt  = {id_acc_r[7:0], b};
        id_left_nxt = (id_left_r != 2'd0) ? id_left_r - 2'd1 : 2'd0;
        if (id_left_nxt == 2'd0) begin
          if (len_left_r != 2'd0) begin
            phase_nxt = ltsp_pkg::PH_LEN;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      ltsp_pkg::PH_LEN: begin
        len_acc_nxt  = {len_acc_r[15:0], b};
        len_left_nxt = (len_left_r != 2'd0) ? len_left_r - 2'd1 : 2'd0;
        if (len_left_nxt == 2'd0) begin
          hdr_done = 1'b1;
        end
      end
      ltsp_pkg::PH_VALUE: begin
        have      = 1'b1;
        present   = 1'b1;
        vleft_nxt = (vleft_r != '0) ? vleft_r - LEN_W'(1) : '0;
        if (vleft_nxt == '0) begin
          last      = 1'b1;
          phase_nxt = ltsp_pkg::PH_TYPE;
        end
      end
      default: begin
        phase_nxt = ltsp_pkg::PH_TYPE;
      end
    endcase

    if (hdr_done) begin
      phase_nxt = ltsp_pkg::PH_TYPE;
      case (kind_r)
        ltsp_pkg::KIND_OBJ_INST: inst_nxt  = id_acc_nxt;
        ltsp_pkg::KIND_RES_INST: rinst_nxt = id_acc_nxt;
        default:                 resid_nxt = id_acc_nxt;
      endcase
      if (kind_r == ltsp_pkg::KIND_OBJ_INST || kind_r == ltsp_pkg::KIND_MULTI_RES) begin
        // A container beyond the stack depth is not tracked.
        if (lvl_r < LVL_W'(NEST_DEPTH)) begin
          for (int i = 0; i < NEST_DEPTH; i++) begin
            if (LVL_W'(i) == lvl_r) begin
              rem_nxt[i] = len_acc_nxt;
            end
          end
          lvl_push = lvl_r + LVL_W'(1);
        end
      end else if (len_acc_nxt == '0) begin
        have = 1'b1;
        last = 1'b1;
      end else begin
        vleft_nxt = len_acc_nxt;
        phase_nxt = ltsp_pkg::PH_VALUE;
      end
    end

    // At a TLV boundary, close exhausted containers from the top down.
    lvl_nxt = lvl_push;
    if (phase_nxt == ltsp_pkg::PH_TYPE) begin
      lvl_nxt = '0;
      for (int j = 1; j <= NEST_DEPTH; j++) begin
        if (LVL_W'(j) <= lvl_push && rem_nxt[j-1] != '0) begin
          lvl_nxt = LVL_W'(j);
        end
      end
    end

    is_rinst = have && (kind_r == ltsp_pkg::KIND_RES_INST);
    trunc    = item.payload_end && (phase_nxt != ltsp_pkg::PH_TYPE || lvl_nxt != '0);

    res.have                      = have || trunc;
    res.data.object_instance_id   = inst_nxt;
    res.data.resource_id          = resid_nxt;
    res.data.resource_instance_id = is_rinst ? rinst_nxt : '0;
    res.data.is_instance_value    = is_rinst;
    res.data.value_byte           = present ? b : 8'd0;
    res.data.value_present        = present;
    res.data.value_last           = last;
    res.data.value_length         = have ? len_acc_nxt : '0;
    res.data.status               = trunc ? ltsp_pkg::STATUS_TRUNC : ltsp_pkg::STATUS_OK;
  end

  // The last byte of a payload returns the whole parser to its reset state.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.payload_end)) begin
      phase_r    <= ltsp_pkg::PH_TYPE;
      kind_r     <= '0;
      id_left_r  <= '0;
      len_left_r <= '0;
      id_acc_r   <= '0;
      len_acc_r  <= '0;
      vleft_r    <= '0;
      lvl_r      <= '0;
      inst_r     <= '0;
      resid_r    <= '0;
      rinst_r    <= '0;
      for (int i = 0; i < NEST_DEPTH; i++) begin
        rem_r[i] <= '0;
      end
    end else if (fire) begin
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      id_left_r  <= id_left_nxt;
      len_left_r <= len_left_nxt;
      id_acc_r   <= id_acc_nxt;
      len_acc_r  <= len_acc_nxt;
      vleft_r    <= vleft_nxt;
      lvl_r      <= lvl_nxt;
      inst_r     <= inst_nxt;
      resid_r    <= resid_nxt;
      rinst_r    <= rinst_nxt;
      for (int i = 0; i < NEST_DEPTH; i++) begin
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  `LTSP_ASSERT_NXT(a_end_resets, fire && item.payload_end,
    phase_r == ltsp_pkg::PH_TYPE && lvl_r == '0, "parser state not cleared after payload end")
  `LTSP_ASSERT_IMP(a_value_nonzero, phase_r == ltsp_pkg::PH_VALUE, vleft_r != '0,
    "value phase entered with no value bytes left")
  `LTSP_ASSERT_IMP(a_empty_value, fire && res.have && !res.data.value_present &&
    res.data.status == ltsp_pkg::STATUS_OK,
    res.data.value_last && res.data.value_length == '0, "malformed empty value result")

endmodule

FILE: rtl/ltsp_out_stage.sv
// Result register that holds one parsed value transaction until it is taken.
`include "lwm2m_tlv_stream_parser_macros.svh"

module ltsp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ltsp_pkg::out_item_t data,
  output logic               space,
  ltsp_out_if.source         out_ch
);

  ltsp_pkg::out_item_t data_r;
  logic                vld_r;
  logic                vld_nxt;

  assign space = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

  assign out_ch.valid                = vld_r;
  assign out_ch.object_instance_id   = data_r.object_instance_id;
  assign out_ch.resource_id          = data_r.resource_id;
  assign out_ch.resource_instance_id = data_r.resource_instance_id;
  assign out_ch.is_instance_value    = data_r.is_instance_value;
  assign out_ch.value_byte           = data_r.value_byte;
  assign out_ch.value_present        = data_r.value_present;
  assign out_ch.value_last           = data_r.value_last;
  assign out_ch.value_length         = data_r.value_length;
  assign out_ch.status               = data_r.status;

  `LTSP_ASSERT_NXT(a_load_shows, load, vld_r, "loaded result not presented")
  `LTSP_ASSERT_IMP(a_load_space, load, space, "result loaded over a waiting transaction")

endmodule

FILE: rtl/lwm2m_tlv_stream_parser.sv
// LwM2M TLV stream parser: one payload byte in, at most one tagged value byte out.
//
// in_ch carries one payload byte per transaction, with payload_end set on the
// final byte of a payload. out_ch carries one result per value byte, tagged
// with the current object instance, resource and resource instance ids; a
// zero-length value gives one empty result, and a payload that stops inside a
// TLV or an open container gives a result with status set.
// A byte taken from in_ch sits in the input register and is decoded from there;
// its result is loaded into the output register once that register has space,
// and out_ch.valid rises as the output register is loaded. The decode step is
// a single register-to-register pass, so one byte is taken every cycle while
// the output register has space.
// The output register frees as it is read, so a stalled receiver holds the
// result and the input register absorbs one more byte before in_ch.ready
// drops. Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a payload; the byte marked payload_end also returns it there.
// NEST_DEPTH sets how many nested containers are tracked.
module lwm2m_tlv_stream_parser #(
  parameter int NEST_DEPTH = 2
) (
  input logic         clk,
  input logic         rst_n,
  ltsp_in_if.sink     in_ch,
  ltsp_out_if.source  out_ch
);

  ltsp_pkg::in_item_t  item;
  logic                item_vld;
  logic                space;
  logic                fire;
  ltsp_pkg::step_res_t res;

  assign fire = item_vld && space;

  ltsp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (fire),
    .item     (item),
    .item_vld (item_vld)
  );

  ltsp_step #(
    .NEST_DEPTH (NEST_DEPTH)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  ltsp_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (fire && res.have),
    .data   (res.data),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule
